### src/pctt_pkg.sv
`timescale 1ns / 1ps
// Package for the pulse counter target tracker: field widths, item and register
// codes, and the structs passed between the modules. Depends on nothing.
package pctt_pkg;

  // Fixed widths of the item fields and of the configuration port.
  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 20;
  localparam int TICK_W     = 8;
  localparam int BURST_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register values after reset.
  localparam logic [TICK_W-1:0]  PULSE_TICKS_RST = 8'd10;
  localparam logic [TICK_W-1:0]  RESET_TICKS_RST = 8'd100;
  localparam logic [BURST_W-1:0] MAX_BURST_RST   = 3'd5;

  // Kind of input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SET  = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_TICKS = 2'd0,
    CFG_RESET_TICKS = 2'd1,
    CFG_MAX_BURST   = 2'd2
  } cfg_idx_t;

  // Current configuration, as held in the top level.
  typedef struct packed {
    logic [TICK_W-1:0]  pulse_ticks;
    logic [TICK_W-1:0]  reset_ticks;
    logic [BURST_W-1:0] max_burst;
  } cfg_t;

  // Outcome of one evaluation of target against believed count.
  typedef struct packed {
    logic               shortcut;  // clearing the display is cheaper
    logic               move;      // target differs from believed count
    logic               up;        // direction of the burst
    logic [BURST_W-1:0] count;     // pulses in the burst
  } eval_t;

endpackage

### src/pctt_in_if.sv
`timescale 1ns / 1ps
// Input channel of the tracker: valid/ready handshake carrying one command item.
// Depends on pctt_pkg for the field widths.
interface pctt_in_if import pctt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

### src/pctt_out_if.sv
`timescale 1ns / 1ps
// Output channel of the tracker: valid/ready handshake carrying one result item.
// Depends on pctt_pkg for the field widths.
interface pctt_out_if import pctt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      inc_level;
  logic                      dec_level;
  logic                      clear_level;
  logic signed [VALUE_W-1:0] believed_count;
  logic signed [VALUE_W-1:0] goal_count;
  logic                      idle;

  modport source (output valid, inc_level, dec_level, clear_level, believed_count,
                  goal_count, idle, input ready);
  modport sink   (input valid, inc_level, dec_level, clear_level, believed_count,
                  goal_count, idle, output ready);
endinterface

### src/pctt_eval.sv
`timescale 1ns / 1ps
// Decision logic of the tracker: compares the cost of a display clear against
// pulsing, and sizes the next burst. Depends on pctt_pkg.
module pctt_eval import pctt_pkg::*; #(
  parameter int COUNT_BITS = 20
) (
  input  logic signed [COUNT_BITS-1:0] goal,
  input  logic signed [COUNT_BITS-1:0] believed,
  input  logic [TICK_W-1:0]            pulse_len,
  input  logic [TICK_W-1:0]            reset_len,
  input  logic [BURST_W-1:0]           burst_len,
  output eval_t                        dec
);

  localparam int DW = COUNT_BITS + 1;
  localparam int MW = COUNT_BITS + 2;
  localparam int PW = MW + TICK_W + 2;

  logic signed [DW-1:0]       delta;
  logic [DW-1:0]              mag;
  logic signed [MW-1:0]       diff;
  logic signed [TICK_W+1:0]   p2;
  logic [TICK_W+1:0]          three_r;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       clear_cost;

  // Distance to the target and its magnitude.
  assign delta = DW'(goal) - DW'(believed);
  assign mag   = delta[DW-1] ? DW'(-delta) : DW'(delta);

  // goal*2p + 3r < |d|*2p is the same test as (|d| - goal)*2p > 3r.
  assign diff       = $signed({1'b0, mag}) - MW'(goal);
  assign p2         = $signed({1'b0, pulse_len, 1'b0});
  assign prod       = PW'(diff) * PW'(p2);
  assign three_r    = {2'b00, reset_len} + {1'b0, reset_len, 1'b0};
  assign clear_cost = PW'($signed({1'b0, three_r}));

  // Decision outputs.
  assign dec.shortcut = prod > clear_cost;
  assign dec.move     = delta != '0;
  assign dec.up       = !delta[DW-1];
  assign dec.count    = (mag > DW'(burst_len)) ? burst_len : mag[BURST_W-1:0];

endmodule

### src/pctt_core.sv
`timescale 1ns / 1ps
// Sequencer of the tracker: target and believed count, phase state machine,
// and the result register with its handshake. Depends on pctt_pkg, pctt_eval
// and the two channel interfaces.
module pctt_core import pctt_pkg::*; #(
  parameter int COUNT_BITS    = 20,
  parameter int UNKNOWN_START = 99999
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  pctt_in_if.sink      in_ch,
  pctt_out_if.source   out_ch
);

  localparam int AW = ((COUNT_BITS > VALUE_W) ? COUNT_BITS : VALUE_W) + 2;
  localparam logic signed [AW-1:0] LIM  = (AW'(1) <<< (COUNT_BITS - 1)) - AW'(1);
  localparam logic signed [AW-1:0] NLIM = -LIM;
  localparam logic signed [AW-1:0] UNK  =
    (AW'(UNKNOWN_START) > LIM) ? LIM : AW'(UNKNOWN_START);

  typedef enum logic [2:0] {
    PH_EVAL   = 3'd0,
    PH_RWAIT1 = 3'd1,
    PH_RHIGH  = 3'd2,
    PH_RWAIT2 = 3'd3,
    PH_PHIGH  = 3'd4,
    PH_PLOW   = 3'd5
  } phase_t;

  // Saturate a wide sum to the count range.
  function automatic logic signed [COUNT_BITS-1:0] clamp_count(
    input logic signed [AW-1:0] x
  );
    logic signed [AW-1:0] y;
    y = x;
    if (x > LIM) begin
      y = LIM;
    end else if (x < NLIM) begin
      y = NLIM;
    end
    return y[COUNT_BITS-1:0];
  endfunction

  phase_t                       phase, phase_next;
  logic signed [COUNT_BITS-1:0] goal, goal_next;
  logic signed [COUNT_BITS-1:0] believed, believed_next;
  logic [TICK_W-1:0]            tick_left, tick_left_next;
  logic [BURST_W-1:0]           pulses_left, pulses_left_next;
  logic [BURST_W-1:0]           pulses_sent, pulses_sent_next;
  logic                         going_up, going_up_next;

  logic                         out_valid;
  logic                         inc_level, dec_level, clear_level, idle;
  logic signed [VALUE_W-1:0]    believed_count, goal_count;

  logic [TICK_W-1:0]            pulse_len, reset_len, tick_dec;
  logic [BURST_W-1:0]           burst_len, sent_inc;
  logic signed [COUNT_BITS-1:0] burst_believed, eval_believed;
  logic                         do_eval, accept;
  eval_t                        dec;

  // A zero register value acts as one.
  assign pulse_len = (cfg.pulse_ticks == '0) ? TICK_W'(1) : cfg.pulse_ticks;
  assign reset_len = (cfg.reset_ticks == '0) ? TICK_W'(1) : cfg.reset_ticks;
  assign burst_len = (cfg.max_burst == '0) ? BURST_W'(1) : cfg.max_burst;

  // Tick countdown and the believed count at the end of a burst.
  assign tick_dec = (tick_left != '0) ? tick_left - TICK_W'(1) : tick_left;
  assign sent_inc = pulses_sent + BURST_W'(1);
  assign burst_believed = going_up ? clamp_count(AW'(believed) + AW'(sent_inc))
                                   : clamp_count(AW'(believed) - AW'(sent_inc));

  pctt_eval #(
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .goal      (goal),
    .believed  (eval_believed),
    .pulse_len (pulse_len),
    .reset_len (reset_len),
    .burst_len (burst_len),
    .dec       (dec)
  );

  // Next state for the item on the input channel.
  always_comb begin
    phase_next       = phase;
    goal_next        = goal;
    believed_next    = believed;
    tick_left_next   = tick_left;
    pulses_left_next = pulses_left;
    pulses_sent_next = pulses_sent;
    going_up_next    = going_up;
    eval_believed    = believed;
    do_eval          = 1'b0;

    case (mode_t'(in_ch.mode))
      MODE_ADD: begin
        goal_next = clamp_count(AW'(goal) + AW'(in_ch.value));
      end
      MODE_SET: begin
        goal_next = clamp_count(AW'(in_ch.value));
      end
      MODE_TICK: begin
        if (phase == PH_EVAL) begin
          do_eval = 1'b1;
        end else if (tick_dec != '0) begin
          tick_left_next = tick_dec;
        end else begin
          case (phase)
            PH_RWAIT1: begin
              phase_next     = PH_RHIGH;
              tick_left_next = reset_len;
            end
            PH_RHIGH: begin
              phase_next     = PH_RWAIT2;
              tick_left_next = reset_len;
            end
            PH_PHIGH: begin
              phase_next     = PH_PLOW;
              tick_left_next = pulse_len;
            end
            PH_PLOW: begin
              pulses_sent_next = sent_inc;
              if (pulses_left > BURST_W'(1)) begin
                pulses_left_next = pulses_left - BURST_W'(1);
                phase_next       = PH_PHIGH;
                tick_left_next   = pulse_len;
              end else begin
                pulses_left_next = '0;
                believed_next    = burst_believed;
                eval_believed    = burst_believed;
                do_eval          = 1'b1;
              end
            end
            default: begin
              do_eval = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase

    // Evaluation: clear the display, start a burst, or stay idle.
    if (do_eval) begin
      if (dec.shortcut) begin
        believed_next  = '0;
        phase_next     = PH_RWAIT1;
        tick_left_next = reset_len;
      end else begin
        phase_next     = PH_EVAL;
        tick_left_next = '0;
        if (dec.move) begin
          going_up_next    = dec.up;
          pulses_left_next = dec.count;
          pulses_sent_next = '0;
          phase_next       = PH_PHIGH;
          tick_left_next   = pulse_len;
        end
      end
    end
  end

  // The output register parts the two sides, so a new item is taken
  // whenever the held result leaves in the same cycle.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_EVAL;
      goal        <= '0;
      believed    <= UNK[COUNT_BITS-1:0];
      tick_left   <= '0;
      pulses_left <= '0;
      pulses_sent <= '0;
      going_up    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        goal           <= goal_next;
        believed       <= believed_next;
        tick_left      <= tick_left_next;
        pulses_left    <= pulses_left_next;
        pulses_sent    <= pulses_sent_next;
        going_up       <= going_up_next;
        out_valid      <= 1'b1;
        inc_level      <= (phase_next == PH_PHIGH) && going_up_next;
        dec_level      <= (phase_next == PH_PHIGH) && !going_up_next;
        clear_level    <= phase_next == PH_RHIGH;
        idle           <= (phase_next == PH_EVAL) && (goal_next == believed_next);
        believed_count <= VALUE_W'(AW'(believed_next));
        goal_count     <= VALUE_W'(AW'(goal_next));
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.inc_level      = inc_level;
  assign out_ch.dec_level      = dec_level;
  assign out_ch.clear_level    = clear_level;
  assign out_ch.believed_count = believed_count;
  assign out_ch.goal_count     = goal_count;
  assign out_ch.idle           = idle;

endmodule

### src/pulse_counter_target_tracker_top.sv
`timescale 1ns / 1ps
// Top level of the pulse counter target tracker: configuration registers and
// the sequencer. Depends on pctt_pkg, pctt_core and the channel interfaces.
//
// Use: the block steers an external display that counts pulses toward a
// target. Each input item on in_ch is a one-millisecond tick, an add of a
// signed amount to the target, a set of it, or a no-op. Every item gives
// exactly one result item on out_ch: the levels of the increment, decrement
// and clear lines after that item, the believed display count, the target,
// and an idle flag.
// Throughput is one item per cycle unless the receiver stalls; a result
// appears in the cycle after its item is accepted, from an output register.
// While a result waits on a stalled receiver, in_ch.ready stays low; it rises
// again when the result is taken, so a new item can enter in that same cycle.
// Reset (rst, synchronous) sets the target to zero, the believed count to the
// unknown start value, the registers to 10, 100 and 5, and empties the output
// register. The registers pulse_ticks (index 0), reset_ticks (index 1) and
// max_burst (index 2) are written through cfg_we, cfg_index and cfg_data.
// Write them only while no item is in flight; the block does not enforce it.
module pulse_counter_target_tracker_top import pctt_pkg::*; #(
  parameter int COUNT_BITS    = 20,
  parameter int UNKNOWN_START = 99999
) (
  input  logic                  clk,
  input  logic                  rst,
  pctt_in_if.sink               in_ch,
  pctt_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks <= PULSE_TICKS_RST;
      cfg.reset_ticks <= RESET_TICKS_RST;
      cfg.max_burst   <= MAX_BURST_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PULSE_TICKS: cfg.pulse_ticks <= cfg_data[TICK_W-1:0];
        CFG_RESET_TICKS: cfg.reset_ticks <= cfg_data[TICK_W-1:0];
        CFG_MAX_BURST:   cfg.max_burst   <= cfg_data[BURST_W-1:0];
        default: ;
      endcase
    end
  end

  pctt_core #(
    .COUNT_BITS    (COUNT_BITS),
    .UNKNOWN_START (UNKNOWN_START)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pulse_counter_target_tracker_top: a cycle-free model of the
// tracker predicts every result item, and a scoreboard compares them as they leave the block.
// Depends on pctt_pkg, pctt_in_if, pctt_out_if and the top level of the block.
module tb;
  import pctt_pkg::*;

  localparam longint COUNT_LIMIT = 524287;
  localparam longint UNKNOWN_COUNT = 99999;
  localparam logic signed [VALUE_W-1:0] VALUE_MOST_NEG = 20'h80000;

  // Sequencer phases of the tracker.
  typedef enum logic [2:0] {
    PH_EVAL       = 3'd0,
    PH_CLR_WAIT1  = 3'd1,
    PH_CLR_HIGH   = 3'd2,
    PH_CLR_WAIT2  = 3'd3,
    PH_PULSE_HIGH = 3'd4,
    PH_PULSE_LOW  = 3'd5
  } track_phase_t;

  // One result item: line levels and counts after an input item.
  typedef struct packed {
    logic                      inc_level;
    logic                      dec_level;
    logic                      clear_level;
    logic signed [VALUE_W-1:0] believed_count;
    logic signed [VALUE_W-1:0] goal_count;
    logic                      idle;
  } line_state_t;

  // Tracks the target and believed count, and holds the line states still awaited.
  class track_checker;
    logic [TICK_W-1:0]  pulse_ticks;
    logic [TICK_W-1:0]  reset_ticks;
    logic [BURST_W-1:0] max_burst;
    longint             goal;
    longint             believed;
    track_phase_t       phase;
    int unsigned        tick_left;
    int unsigned        pulses_left;
    logic [BURST_W-1:0] pulses_sent;
    bit                 going_up;
    line_state_t        awaited[$];
    int                 errors;

    function new();
      pulse_ticks = PULSE_TICKS_RST;
      reset_ticks = RESET_TICKS_RST;
      max_burst   = MAX_BURST_RST;
      goal        = 0;
      believed    = clamp(UNKNOWN_COUNT);
      phase       = PH_EVAL;
      tick_left   = 0;
      pulses_left = 0;
      pulses_sent = '0;
      going_up    = 0;
      errors      = 0;
    endfunction

    function longint clamp(longint v);
      if (v > COUNT_LIMIT) return COUNT_LIMIT;
      if (v < -COUNT_LIMIT) return -COUNT_LIMIT;
      return v;
    endfunction

    // A register value of zero behaves as one.
    function longint at_least_one(logic [TICK_W-1:0] v);
      return (v == 0) ? 1 : longint'(v);
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PULSE_TICKS: pulse_ticks = data;
        CFG_RESET_TICKS: reset_ticks = data;
        CFG_MAX_BURST:   max_burst = data[BURST_W-1:0];
        default: ;
      endcase
    endfunction

    // Decide between clearing the display, a pulse burst, or staying idle.
    function void evaluate();
      longint diff, mag, p, r, mb;
      diff = goal - believed;
      mag  = (diff < 0) ? -diff : diff;
      p    = at_least_one(pulse_ticks);
      r    = at_least_one(reset_ticks);
      mb   = at_least_one(TICK_W'(max_burst));
      if (goal * 2 * p + 3 * r < mag * 2 * p) begin
        believed  = 0;
        phase     = PH_CLR_WAIT1;
        tick_left = 32'(r);
        return;
      end
      phase     = PH_EVAL;
      tick_left = 0;
      if (diff == 0) return;
      going_up    = (diff > 0);
      pulses_left = 32'((mag > mb) ? mb : mag);
      pulses_sent = '0;
      phase       = PH_PULSE_HIGH;
      tick_left   = 32'(p);
    endfunction

    // Move to the next timed phase once the current one has run out.
    function void advance();
      case (phase)
        PH_CLR_WAIT1: begin
          phase     = PH_CLR_HIGH;
          tick_left = 32'(at_least_one(reset_ticks));
        end
        PH_CLR_HIGH: begin
          phase     = PH_CLR_WAIT2;
          tick_left = 32'(at_least_one(reset_ticks));
        end
        PH_PULSE_HIGH: begin
          phase     = PH_PULSE_LOW;
          tick_left = 32'(at_least_one(pulse_ticks));
        end
        PH_PULSE_LOW: begin
          pulses_sent = pulses_sent + 1'b1;
          if (pulses_left > 1) begin
            pulses_left--;
            phase     = PH_PULSE_HIGH;
            tick_left = 32'(at_least_one(pulse_ticks));
          end else begin
            pulses_left = 0;
            if (going_up) believed = clamp(believed + longint'(pulses_sent));
            else believed = clamp(believed - longint'(pulses_sent));
            evaluate();
          end
        end
        default: evaluate();
      endcase
    endfunction

    // Called for every accepted input item: updates the model and queues its result.
    function void note_item(mode_t m, logic signed [VALUE_W-1:0] v);
      line_state_t res;
      case (m)
        MODE_ADD: goal = clamp(goal + longint'(v));
        MODE_SET: goal = clamp(longint'(v));
        MODE_TICK: begin
          if (phase == PH_EVAL) begin
            evaluate();
          end else begin
            if (tick_left > 0) tick_left--;
            if (tick_left == 0) advance();
          end
        end
        default: ;
      endcase
      res.inc_level      = (phase == PH_PULSE_HIGH) && going_up;
      res.dec_level      = (phase == PH_PULSE_HIGH) && !going_up;
      res.clear_level    = (phase == PH_CLR_HIGH);
      res.believed_count = believed[VALUE_W-1:0];
      res.goal_count     = goal[VALUE_W-1:0];
      res.idle           = (phase == PH_EVAL) && (goal == believed);
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [VALUE_W-1:0] want,
                                logic signed [VALUE_W-1:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    // Called for every accepted result item.
    function void check_result(line_state_t got);
      line_state_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result item with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("inc_level", VALUE_W'(want.inc_level), VALUE_W'(got.inc_level));
      compare_field("dec_level", VALUE_W'(want.dec_level), VALUE_W'(got.dec_level));
      compare_field("clear_level", VALUE_W'(want.clear_level), VALUE_W'(got.clear_level));
      compare_field("believed_count", want.believed_count, got.believed_count);
      compare_field("goal_count", want.goal_count, got.goal_count);
      compare_field("idle", VALUE_W'(want.idle), VALUE_W'(got.idle));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    steady;
  track_checker          sb;

  pctt_in_if  in_ch ();
  pctt_out_if out_ch ();

  pulse_counter_target_tracker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous limit on the whole run.
  initial begin
    #2_000_000;
    $display("FAIL pulse_counter_target_tracker_top");
    $finish;
  end

  // Receiver stalls at random, except during a steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.inc_level, out_ch.dec_level, out_ch.clear_level,
                        out_ch.believed_count, out_ch.goal_count, out_ch.idle});
    end
  end

  // Mostly small amounts near zero, with full-range and extreme values mixed in.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return VALUE_W'(int'($urandom_range(0, 60)) - 30);
    if (sel < 70) return VALUE_W'(int'($urandom_range(0, 2000)) - 1000);
    if (sel < 88) return VALUE_W'($urandom);
    case ($urandom_range(0, 3))
      0: return VALUE_W'(524287);
      1: return VALUE_W'(-524287);
      2: return VALUE_MOST_NEG;
      default: return '0;
    endcase
  endfunction

  function automatic mode_t pick_mode();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 72) return MODE_TICK;
    if (sel < 84) return MODE_ADD;
    if (sel < 94) return MODE_SET;
    return MODE_NOP;
  endfunction

  // Offer one input item; entered and left at a falling edge.
  task automatic send_item(input mode_t m, input logic signed [VALUE_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(m, v);
    @(negedge clk);
  endtask

  // Stop offering items until every expected result has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three registers; max_burst gets random upper data bits, which it ignores.
  task automatic set_config(input int p, input int r, input int b);
    logic [CFG_DATA_W-1:0] burst_data;
    burst_data = {5'($urandom_range(0, 31)), b[BURST_W-1:0]};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PULSE_TICKS;
    cfg_data  <= p[CFG_DATA_W-1:0];
    sb.write_reg(CFG_PULSE_TICKS, p[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_index <= CFG_RESET_TICKS;
    cfg_data  <= r[CFG_DATA_W-1:0];
    sb.write_reg(CFG_RESET_TICKS, r[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_index <= CFG_MAX_BURST;
    cfg_data  <= burst_data;
    sb.write_reg(CFG_MAX_BURST, burst_data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One setting of the registers followed by a run of random items.
  task automatic run_phase(input int p, input int r, input int b, input int n,
                           input bit calm, input bit hold_mid);
    logic [BURST_W-1:0] upper_free;
    upper_free = b[BURST_W-1:0];
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PULSE_TICKS;
    cfg_data  <= p[CFG_DATA_W-1:0];
    sb.write_reg(CFG_PULSE_TICKS, p[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_index <= CFG_RESET_TICKS;
    cfg_data  <= r[CFG_DATA_W-1:0];
    sb.write_reg(CFG_RESET_TICKS, r[CFG_DATA_W-1:0]);
    @(negedge clk);
    cfg_index <= CFG_MAX_BURST;
    cfg_data  <= {3'b101, 2'b10, upper_free};
    sb.write_reg(CFG_MAX_BURST, {3'b101, 2'b10, upper_free});
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    steady = calm;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) wait_drained();
      send_item(pick_mode(), pick_value());
    end
    steady = 1'b0;
  endtask

  // Main stimulus.
  initial begin
    sb           = new();
    steady       = 1'b0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_PULSE_TICKS;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_TICK;
    in_ch.value  = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Shortest timings and the longest burst for the directed part.
    set_config(1, 1, 7);

    // The unknown start count forces a clear of the display, then the block settles idle.
    repeat (4) send_item(MODE_TICK, VALUE_W'($urandom));
    // A small target: a burst starts from idle and shows its line on the same tick.
    send_item(MODE_SET, VALUE_W'(9));
    repeat (6) send_item(MODE_TICK, VALUE_W'($urandom));
    send_item(MODE_ADD, VALUE_W'(-1));
    repeat (3) send_item(MODE_TICK, VALUE_W'($urandom));
    // The unused mode changes nothing but still returns a result.
    send_item(MODE_NOP, VALUE_MOST_NEG);
    // Target saturation at both ends.
    send_item(MODE_SET, VALUE_W'(524287));
    send_item(MODE_ADD, VALUE_W'(524287));
    send_item(MODE_TICK, '0);
    send_item(MODE_SET, VALUE_MOST_NEG);
    send_item(MODE_ADD, VALUE_W'(-524287));
    // A negative target keeps clearing the display.
    repeat (5) send_item(MODE_TICK, 20'hFFFFF);

    // Random part: several settings, with the extremes and zero registers among them.
    run_phase(1, 1, 7, 90, 1'b0, 1'b1);
    run_phase(0, 0, 0, 70, 1'b0, 1'b0);
    run_phase(2, 3, 1, 70, 1'b0, 1'b0);
    run_phase(3, 1, 4, 70, 1'b1, 1'b0);
    run_phase(1, 2, 2, 70, 1'b0, 1'b0);
    run_phase(10, 100, 5, 60, 1'b0, 1'b0);
    run_phase(255, 255, 6, 30, 1'b0, 1'b0);
    run_phase(1, 1, 3, 90, 1'b0, 1'b0);

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS pulse_counter_target_tracker_top");
    end else begin
      $display("FAIL pulse_counter_target_tracker_top");
    end
    $finish;
  end

endmodule
